// ===== src/fsr_pkg.sv =====
// shared types and constants for the framebuffer shape rasterizer
// used by fsr_ctrl, fsr_datapath and framebuffer_shape_rasterizer
`timescale 1ns / 1ps

package fsr_pkg;

   localparam int FRAME_WIDTH_DEF  = 128;
   localparam int FRAME_HEIGHT_DEF = 128;

   // width of scan coordinates and box sizes
   localparam int DIM_W = 11;

   localparam logic [3:0] KIND_CLEAR = 4'd0;
   localparam logic [3:0] KIND_HLINE = 4'd1;
   localparam logic [3:0] KIND_VLINE = 4'd2;
   localparam logic [3:0] KIND_FILL  = 4'd3;
   localparam logic [3:0] KIND_RECT  = 4'd4;
   localparam logic [3:0] KIND_GRID  = 4'd5;
   localparam logic [3:0] KIND_RING  = 4'd6;
   localparam logic [3:0] KIND_DISC  = 4'd7;
   localparam logic [3:0] KIND_READ  = 4'd8;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CLIP     = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;

   typedef enum logic [3:0] {
      ST_INIT_LOAD,
      ST_INIT_SCAN,
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_GRID_START,
      ST_GRID_DIV,
      ST_GRID_LOAD,
      ST_GRID_SCAN,
      ST_GRID_NEXT,
      ST_READ,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic {
      BOX_CMD,
      BOX_GRID
   } box_src_type;

   typedef struct packed {
      logic        latch;
      logic        scan_load;
      box_src_type box_src;
      logic        scan_step;
      logic        grid_init;
      logic        grid_adv;
      logic        div_start;
      logic        read_issue;
      logic        rsp_fire;
   } ctl_type;

   typedef struct packed {
      logic [3:0] kind;
      logic       zero_div;
      logic       scan_end;
      logic       div_busy;
      logic       grid_last;
      logic       grid_vert;
   } sts_type;

endpackage

// ===== src/fsr_ctrl.sv =====
// command sequencer of the framebuffer shape rasterizer
// depends on fsr_pkg; drives fsr_datapath through ctl_type, watches sts_type
`timescale 1ns / 1ps

module fsr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fsr_pkg::sts_type sts,
   output fsr_pkg::ctl_type ctl
);

   fsr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsr_pkg::ST_INIT_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsr_pkg::ST_INIT_LOAD: state_in = fsr_pkg::ST_INIT_SCAN;
         fsr_pkg::ST_INIT_SCAN: begin
            if (sts.scan_end) state_in = fsr_pkg::ST_IDLE;
         end
         fsr_pkg::ST_IDLE: begin
            if (start) state_in = fsr_pkg::ST_SETUP;
         end
         fsr_pkg::ST_SETUP: begin
            if (sts.kind inside {[fsr_pkg::KIND_CLEAR:fsr_pkg::KIND_RECT],
                                 fsr_pkg::KIND_RING, fsr_pkg::KIND_DISC}) begin
               state_in = fsr_pkg::ST_SCAN;
            end else if (sts.kind == fsr_pkg::KIND_GRID) begin
               state_in = sts.zero_div ? fsr_pkg::ST_DONE : fsr_pkg::ST_GRID_START;
            end else if (sts.kind == fsr_pkg::KIND_READ) begin
               state_in = fsr_pkg::ST_READ;
            end else begin
               state_in = fsr_pkg::ST_DONE;
            end
         end
         fsr_pkg::ST_SCAN: begin
            if (sts.scan_end) state_in = fsr_pkg::ST_DONE;
         end
         fsr_pkg::ST_GRID_START: state_in = fsr_pkg::ST_GRID_DIV;
         fsr_pkg::ST_GRID_DIV: begin
            if (!sts.div_busy) state_in = fsr_pkg::ST_GRID_LOAD;
         end
         fsr_pkg::ST_GRID_LOAD: state_in = fsr_pkg::ST_GRID_SCAN;
         fsr_pkg::ST_GRID_SCAN: begin
            if (sts.scan_end) begin
               state_in = (sts.grid_last && sts.grid_vert) ? fsr_pkg::ST_DONE
                                                           : fsr_pkg::ST_GRID_NEXT;
            end
         end
         fsr_pkg::ST_GRID_NEXT: state_in = fsr_pkg::ST_GRID_START;
         fsr_pkg::ST_READ:      state_in = fsr_pkg::ST_READ_WAIT;
         fsr_pkg::ST_READ_WAIT: state_in = fsr_pkg::ST_DONE;
         fsr_pkg::ST_DONE:      state_in = fsr_pkg::ST_IDLE;
         default:               state_in = fsr_pkg::ST_INIT_LOAD;
      endcase
   end

   always_comb begin
      ctl            = '0;
      ctl.box_src    = fsr_pkg::BOX_CMD;
      busy           = (state_ff != fsr_pkg::ST_IDLE);
      case (state_ff)
         fsr_pkg::ST_INIT_LOAD: ctl.scan_load = 1'b1;
         fsr_pkg::ST_INIT_SCAN: ctl.scan_step = 1'b1;
         fsr_pkg::ST_IDLE:      ctl.latch     = start;
         fsr_pkg::ST_SETUP: begin
            ctl.scan_load = 1'b1;
            ctl.grid_init = 1'b1;
         end
         fsr_pkg::ST_SCAN:       ctl.scan_step = 1'b1;
         fsr_pkg::ST_GRID_START: ctl.div_start = 1'b1;
         fsr_pkg::ST_GRID_LOAD: begin
            ctl.scan_load = 1'b1;
            ctl.box_src   = fsr_pkg::BOX_GRID;
         end
         fsr_pkg::ST_GRID_SCAN: ctl.scan_step  = 1'b1;
         fsr_pkg::ST_GRID_NEXT: ctl.grid_adv   = 1'b1;
         fsr_pkg::ST_READ:      ctl.read_issue = 1'b1;
         fsr_pkg::ST_DONE:      ctl.rsp_fire   = 1'b1;
         default:               ctl.latch      = 1'b0;
      endcase
   end

endmodule

// ===== src/fsr_datapath.sv =====
// pixel store, box scanner, circle test and grid divider of the rasterizer
// depends on fsr_pkg; sequenced by fsr_ctrl
`timescale 1ns / 1ps

module fsr_datapath #(
   parameter int FRAME_WIDTH  = fsr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = fsr_pkg::FRAME_HEIGHT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  fsr_pkg::ctl_type ctl,
   output fsr_pkg::sts_type sts,
   input  logic [3:0]       req_kind,
   input  logic [7:0]       req_x_pos,
   input  logic [7:0]       req_y_pos,
   input  logic [7:0]       req_extent_x,
   input  logic [7:0]       req_extent_y,
   input  logic [7:0]       req_div_x,
   input  logic [7:0]       req_div_y,
   input  logic [7:0]       req_diameter,
   input  logic [31:0]      req_color,
   output logic             rsp_valid,
   output logic [31:0]      rsp_read_color,
   output logic [1:0]       rsp_status
);

   localparam int DW   = fsr_pkg::DIM_W;
   localparam int NPIX = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW   = $clog2(NPIX);
   localparam int SW   = DW + 6;

   // latched command
   logic [3:0]  kind_ff;
   logic [7:0]  xp_ff, yp_ff, ex_ff, ey_ff, dvx_ff, dvy_ff;
   logic [6:0]  r_ff;
   logic [31:0] color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= fsr_pkg::KIND_CLEAR;
         color_ff <= '0;
      end else if (ctl.latch) begin
         kind_ff  <= req_kind;
         xp_ff    <= req_x_pos;
         yp_ff    <= req_y_pos;
         ex_ff    <= req_extent_x;
         ey_ff    <= req_extent_y;
         dvx_ff   <= req_div_x;
         dvy_ff   <= req_div_y;
         r_ff     <= req_diameter[7:1];
         color_ff <= req_color;
      end
   end

   logic zero_div;
   assign zero_div = (dvx_ff == 8'd0) || (dvy_ff == 8'd0);

   // grid index and divider
   logic [7:0]  gi_ff;
   logic        vert_ff;
   logic [15:0] quo_ff;
   logic [7:0]  rem_ff;
   logic [4:0]  dcnt_ff;
   logic        dbusy_ff;
   logic [7:0]  g_div, g_ext, q;
   logic [8:0]  rem_sh;
   logic        grid_last;

   assign g_div     = vert_ff ? dvx_ff : dvy_ff;
   assign g_ext     = vert_ff ? ex_ff : ey_ff;
   assign grid_last = (gi_ff == g_div);
   assign rem_sh    = {rem_ff, quo_ff[15]};
   assign q         = quo_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         vert_ff  <= 1'b0;
         gi_ff    <= '0;
      end else begin
         if (ctl.grid_init) begin
            gi_ff   <= '0;
            vert_ff <= 1'b0;
         end else if (ctl.grid_adv) begin
            if (grid_last) begin
               gi_ff   <= '0;
               vert_ff <= 1'b1;
            end else begin
               gi_ff <= gi_ff + 8'd1;
            end
         end
         if (ctl.div_start) begin
            quo_ff   <= 16'(gi_ff) * 16'(g_ext);
            rem_ff   <= '0;
            dcnt_ff  <= 5'd16;
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff) begin
            if (rem_sh >= {1'b0, g_div}) begin
               rem_ff <= 8'(rem_sh - {1'b0, g_div});
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[7:0];
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 5'd1;
            if (dcnt_ff == 5'd1) dbusy_ff <= 1'b0;
         end
      end
   end

   // box selection
   logic [DW-1:0] bx0, by0, bw, bh;

   always_comb begin
      bx0 = DW'(xp_ff);
      by0 = DW'(yp_ff);
      bw  = DW'(ex_ff);
      bh  = DW'(ey_ff);
      if (ctl.box_src == fsr_pkg::BOX_GRID) begin
         if (vert_ff) begin
            bx0 = DW'(xp_ff) + DW'(q);
            bw  = DW'(1);
         end else begin
            by0 = DW'(yp_ff) + DW'(q);
            bh  = DW'(1);
         end
      end else begin
         case (kind_ff)
            fsr_pkg::KIND_CLEAR: begin
               bx0 = '0;
               by0 = '0;
               bw  = DW'(FRAME_WIDTH);
               bh  = DW'(FRAME_HEIGHT);
            end
            fsr_pkg::KIND_HLINE: begin
               bw = (xp_ff <= ex_ff) ? DW'(ex_ff) - DW'(xp_ff) + DW'(1) : '0;
               bh = DW'(1);
            end
            fsr_pkg::KIND_VLINE: begin
               bw = DW'(1);
               bh = (yp_ff <= ey_ff) ? DW'(ey_ff) - DW'(yp_ff) + DW'(1) : '0;
            end
            fsr_pkg::KIND_RING, fsr_pkg::KIND_DISC: begin
               bw = DW'({r_ff, 1'b1});
               bh = DW'({r_ff, 1'b1});
            end
            default: begin
               bw = DW'(ex_ff);
               bh = DW'(ey_ff);
            end
         endcase
      end
   end

   // scanner with incremental squared distance
   logic [DW-1:0]        x0_ff, w_ff, h_ff, cx_ff, cy_ff, sx_ff, sy_ff;
   logic signed [SW-1:0] dx2_ff, dy2_ff, r2_ff;
   logic signed [SW-1:0] dx_s, dy_s, d2, diff, r_s;
   logic                 empty, last_x, last_y, hit, inframe, active;

   assign empty  = (w_ff == '0) || (h_ff == '0);
   assign last_x = (cx_ff == w_ff - DW'(1));
   assign last_y = (cy_ff == h_ff - DW'(1));
   assign r_s    = SW'(r_ff);
   assign dx_s   = SW'(cx_ff) - r_s;
   assign dy_s   = SW'(cy_ff) - r_s;
   assign d2     = dx2_ff + dy2_ff;
   assign diff   = d2 - r2_ff;
   assign active = ctl.scan_step && !empty;

   always_ff @(posedge clock) begin
      if (ctl.scan_load) begin
         x0_ff  <= bx0;
         w_ff   <= bw;
         h_ff   <= bh;
         cx_ff  <= '0;
         cy_ff  <= '0;
         sx_ff  <= bx0;
         sy_ff  <= by0;
         r2_ff  <= SW'(r_ff) * SW'(r_ff);
         dx2_ff <= SW'(r_ff) * SW'(r_ff);
         dy2_ff <= SW'(r_ff) * SW'(r_ff);
      end else if (active) begin
         if (last_x) begin
            cx_ff  <= '0;
            sx_ff  <= x0_ff;
            dx2_ff <= r2_ff;
            cy_ff  <= cy_ff + DW'(1);
            sy_ff  <= sy_ff + DW'(1);
            dy2_ff <= dy2_ff + (dy_s <<< 1) + SW'(1);
         end else begin
            cx_ff  <= cx_ff + DW'(1);
            sx_ff  <= sx_ff + DW'(1);
            dx2_ff <= dx2_ff + (dx_s <<< 1) + SW'(1);
         end
      end
   end

   always_comb begin
      case (kind_ff)
         fsr_pkg::KIND_RECT: hit = (cx_ff == '0) || last_x || (cy_ff == '0) || last_y;
         fsr_pkg::KIND_RING: hit = (diff <= r_s) && (diff >= -r_s);
         fsr_pkg::KIND_DISC: hit = (diff <= 0);
         default:            hit = 1'b1;
      endcase
   end

   assign inframe = (sx_ff < DW'(FRAME_WIDTH)) && (sy_ff < DW'(FRAME_HEIGHT));

   // pixel store
   logic [31:0]   mem [NPIX];
   logic [31:0]   rdata_ff;
   logic [AW-1:0] waddr, raddr;
   logic          we, rd_in, rd_ok_ff, clip_ff;

   assign we    = active && hit && inframe;
   assign waddr = AW'(AW'(sy_ff) * AW'(FRAME_WIDTH) + AW'(sx_ff));
   assign rd_in = (DW'(xp_ff) < DW'(FRAME_WIDTH)) && (DW'(yp_ff) < DW'(FRAME_HEIGHT));
   assign raddr = AW'(AW'(yp_ff) * AW'(FRAME_WIDTH) + AW'(xp_ff));

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= color_ff;
      if (ctl.read_issue) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff  <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else if (ctl.latch) begin
         clip_ff  <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (active && hit && !inframe) clip_ff <= 1'b1;
         if (ctl.read_issue) begin
            rd_ok_ff <= rd_in;
            if (!rd_in) clip_ff <= 1'b1;
         end
      end
   end

   // result transaction
   assign rsp_valid      = ctl.rsp_fire;
   assign rsp_read_color = (kind_ff == fsr_pkg::KIND_READ && rd_ok_ff) ? rdata_ff : '0;
   assign rsp_status     = (kind_ff == fsr_pkg::KIND_GRID && zero_div) ? fsr_pkg::STATUS_ZERO_DIV
                         : clip_ff ? fsr_pkg::STATUS_CLIP : fsr_pkg::STATUS_OK;

   assign sts.kind      = kind_ff;
   assign sts.zero_div  = zero_div;
   assign sts.scan_end  = empty || (last_x && last_y);
   assign sts.div_busy  = dbusy_ff;
   assign sts.grid_last = grid_last;
   assign sts.grid_vert = vert_ff;

endmodule

// ===== src/framebuffer_shape_rasterizer.sv =====
// top level of the framebuffer shape rasterizer
// depends on fsr_pkg, fsr_ctrl and fsr_datapath
`timescale 1ns / 1ps

// usage
// a command transaction is taken when start is high and busy is low; the
// req_ fields are sampled at that edge. one result transaction follows per
// command: rsp_valid is high for one cycle with rsp_read_color and
// rsp_status; the receiver cannot stall, so it must take it then.
// drawing: clear walks the whole frame and lines, fill, rectangles, ring and
// disc walk their pixel box, at one pixel per cycle through the single write
// port of the pixel store; ring and disc use a box of side 2r+1. a grid runs
// the bit-serial offset divider for each line and then walks that line.
// reset: after reset the block sweeps the store to zero, one pixel a cycle,
// with busy high.
// one command is in flight at a time; busy stays high until its result.

module framebuffer_shape_rasterizer #(
   parameter int FRAME_WIDTH  = fsr_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = fsr_pkg::FRAME_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_kind,
   input  logic [7:0]  req_x_pos,
   input  logic [7:0]  req_y_pos,
   input  logic [7:0]  req_extent_x,
   input  logic [7:0]  req_extent_y,
   input  logic [7:0]  req_div_x,
   input  logic [7:0]  req_div_y,
   input  logic [7:0]  req_diameter,
   input  logic [31:0] req_color,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_color,
   output logic [1:0]  rsp_status
);

   fsr_pkg::ctl_type ctl;
   fsr_pkg::sts_type sts;

   fsr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   fsr_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_extent_x   (req_extent_x),
      .req_extent_y   (req_extent_y),
      .req_div_x      (req_div_x),
      .req_div_y      (req_div_y),
      .req_diameter   (req_diameter),
      .req_color      (req_color),
      .rsp_valid      (rsp_valid),
      .rsp_read_color (rsp_read_color),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== sim/tb_framebuffer_shape_rasterizer.sv =====
// self-checking testbench for framebuffer_shape_rasterizer
// depends on fsr_pkg and the rtl; holds its own pixel frame model to predict results
`timescale 1ns / 1ps

module tb_framebuffer_shape_rasterizer;

   localparam int FW = fsr_pkg::FRAME_WIDTH_DEF;
   localparam int FH = fsr_pkg::FRAME_HEIGHT_DEF;
   localparam int IDLE_LIMIT = 300000;
   localparam int N_RANDOM = 100;
   localparam logic [3:0] KIND_SPARE_LO = 4'd9;
   localparam logic [3:0] KIND_SPARE_HI = 4'd15;

   typedef struct {
      logic [3:0]  kind;
      logic [7:0]  x, y, ex, ey, dvx, dvy, dia;
      logic [31:0] color;
   } draw_cmd_type;

   typedef struct {
      logic [31:0] rd;
      logic [1:0]  st;
   } draw_rsp_type;

   typedef struct {
      draw_cmd_type c;
      bit           typed;
      draw_rsp_type r;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_kind = '0;
   logic [7:0]  req_x_pos = '0, req_y_pos = '0, req_extent_x = '0, req_extent_y = '0;
   logic [7:0]  req_div_x = '0, req_div_y = '0, req_diameter = '0;
   logic [31:0] req_color = '0;
   logic        rsp_valid;
   logic [31:0] rsp_read_color;
   logic [1:0]  rsp_status;

   logic [31:0]  frame_model [FW*FH];
   bit           clip_hit;
   draw_rsp_type pending_rsp [$];
   int           errors = 0;
   int           idle_cycles = 0;
   int           n_sent = 0;
   int           n_checked = 0;

   framebuffer_shape_rasterizer u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_x_pos(req_x_pos), .req_y_pos(req_y_pos),
      .req_extent_x(req_extent_x), .req_extent_y(req_extent_y),
      .req_div_x(req_div_x), .req_div_y(req_div_y), .req_diameter(req_diameter),
      .req_color(req_color), .rsp_valid(rsp_valid),
      .rsp_read_color(rsp_read_color), .rsp_status(rsp_status)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   task automatic plot(int px, int py, logic [31:0] c);
      if (px < FW && py < FH) frame_model[py*FW + px] = c;
      else clip_hit = 1'b1;
   endtask

   task automatic span_row(int x0, int cnt, int py, logic [31:0] c);
      for (int i = 0; i < cnt; i++) plot(x0 + i, py, c);
   endtask

   task automatic span_col(int y0, int cnt, int px, logic [31:0] c);
      for (int i = 0; i < cnt; i++) plot(px, y0 + i, c);
   endtask

   task automatic plot_round(int x0, int y0, int d, bit ring, logic [31:0] c);
      int r, r2, d2;
      r = d / 2;
      r2 = r * r;
      for (int dy = -r; dy <= r; dy++)
         for (int dx = -r; dx <= r; dx++) begin
            d2 = dx*dx + dy*dy - r2;
            if (ring ? (d2 <= r && d2 >= -r) : (d2 <= 0)) plot(x0 + r + dx, y0 + r + dy, c);
         end
   endtask

   // updates the frame model and returns the result the command should give
   task automatic draw_predict(draw_cmd_type c, output draw_rsp_type e);
      int x, y, ex, ey, vx, vy;
      x = c.x; y = c.y; ex = c.ex; ey = c.ey; vx = c.dvx; vy = c.dvy;
      e.rd = '0;
      e.st = fsr_pkg::STATUS_OK;
      clip_hit = 1'b0;
      case (c.kind)
         fsr_pkg::KIND_CLEAR: for (int i = 0; i < FW*FH; i++) frame_model[i] = c.color;
         fsr_pkg::KIND_HLINE: if (x <= ex) span_row(x, ex - x + 1, y, c.color);
         fsr_pkg::KIND_VLINE: if (y <= ey) span_col(y, ey - y + 1, x, c.color);
         fsr_pkg::KIND_FILL: for (int i = 0; i < ey; i++) span_row(x, ex, y + i, c.color);
         fsr_pkg::KIND_RECT: if (ex != 0 && ey != 0) begin
            span_row(x, ex, y, c.color);
            span_row(x, ex, y + ey - 1, c.color);
            span_col(y, ey, x, c.color);
            span_col(y, ey, x + ex - 1, c.color);
         end
         fsr_pkg::KIND_GRID: if (vx == 0 || vy == 0) e.st = fsr_pkg::STATUS_ZERO_DIV;
         else begin
            for (int i = 0; i <= vy; i++) span_row(x, ex, y + (i*ey)/vy, c.color);
            for (int i = 0; i <= vx; i++) span_col(y, ey, x + (i*ex)/vx, c.color);
         end
         fsr_pkg::KIND_RING: plot_round(x, y, c.dia, 1'b1, c.color);
         fsr_pkg::KIND_DISC: plot_round(x, y, c.dia, 1'b0, c.color);
         fsr_pkg::KIND_READ: if (x < FW && y < FH) e.rd = frame_model[y*FW + x];
                    else clip_hit = 1'b1;
         default: ;
      endcase
      if (e.st == fsr_pkg::STATUS_OK && clip_hit) e.st = fsr_pkg::STATUS_CLIP;
   endtask

   task automatic issue_cmd(draw_cmd_type c, bit typed, draw_rsp_type want);
      draw_rsp_type e;
      req_kind <= c.kind; req_x_pos <= c.x; req_y_pos <= c.y;
      req_extent_x <= c.ex; req_extent_y <= c.ey; req_div_x <= c.dvx; req_div_y <= c.dvy;
      req_diameter <= c.dia; req_color <= c.color;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      draw_predict(c, e);
      pending_rsp.push_back(typed ? want : e);
      n_sent++;
   endtask

   function automatic draw_cmd_type mk(logic [3:0] k, logic [7:0] x, logic [7:0] y,
                                       logic [7:0] ex, logic [7:0] ey, logic [7:0] vx,
                                       logic [7:0] vy, logic [7:0] d, logic [31:0] col);
      draw_cmd_type c;
      c.kind = k; c.x = x; c.y = y; c.ex = ex; c.ey = ey;
      c.dvx = vx; c.dvy = vy; c.dia = d; c.color = col;
      return c;
   endfunction

   function automatic draw_cmd_type rand_cmd();
      draw_cmd_type c;
      int pick;
      bit wide;
      wide = ($urandom_range(0, 99) < 5);
      pick = $urandom_range(0, 99);
      c = mk(fsr_pkg::KIND_READ, 8'($urandom_range(0, 47)), 8'($urandom_range(0, 47)),
             8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
             8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
             8'($urandom_range(0, 20)), $urandom);
      if (pick < 2) c.kind = fsr_pkg::KIND_CLEAR;
      else if (pick < 6) c.kind = 4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      else if (pick < 66)
         c.kind = 4'($urandom_range(fsr_pkg::KIND_HLINE, fsr_pkg::KIND_DISC));
      if ($urandom_range(0, 9) == 0) begin
         c.x = 8'($urandom_range(100, 255));
         c.y = 8'($urandom_range(100, 255));
      end
      if (c.kind == fsr_pkg::KIND_HLINE) c.ex = 8'(c.x + $urandom_range(0, 20) - 3);
      if (c.kind == fsr_pkg::KIND_VLINE) c.ey = 8'(c.y + $urandom_range(0, 20) - 3);
      if (wide) begin
         c.x = 8'($urandom); c.y = 8'($urandom); c.ex = 8'($urandom); c.ey = 8'($urandom);
         c.dvx = 8'($urandom); c.dvy = 8'($urandom); c.dia = 8'($urandom);
         if (c.kind == fsr_pkg::KIND_GRID) begin
            c.ex = c.ex & 8'h1f;
            c.ey = c.ey & 8'h1f;
         end
      end
      return c;
   endfunction

   // result checker
   always @(posedge clock) begin
      draw_rsp_type e;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result transaction", rsp_read_color, 32'h0);
         end else begin
            e = pending_rsp.pop_front();
            n_checked++;
            if (rsp_read_color !== e.rd) report_mismatch("read_color", rsp_read_color, e.rd);
            if (rsp_status !== e.st) report_mismatch("status", rsp_status, e.st);
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((start && busy === 1'b0 && !reset) || rsp_valid === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_rsp.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      table_row_type rows [$];
      draw_rsp_type none;
      none.rd = '0;
      none.st = fsr_pkg::STATUS_OK;
      for (int i = 0; i < FW*FH; i++) frame_model[i] = '0;

      rows.push_back('{mk(fsr_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                       '{0, fsr_pkg::STATUS_OK}});
      rows.push_back('{mk(fsr_pkg::KIND_READ, 255, 255, 0, 0, 0, 0, 0, 0), 1,
                       '{0, fsr_pkg::STATUS_CLIP}});
      rows.push_back('{mk(fsr_pkg::KIND_HLINE, 3, 2, 10, 0, 0, 0, 0, 32'ha5a5_0001), 0, none});
      rows.push_back('{mk(fsr_pkg::KIND_READ, 5, 2, 0, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{mk(fsr_pkg::KIND_HLINE, 10, 4, 3, 0, 0, 0, 0, 32'h1), 1,
                       '{0, fsr_pkg::STATUS_OK}});
      rows.push_back('{mk(fsr_pkg::KIND_VLINE, 127, 0, 0, 127, 0, 0, 0, 32'h0000_ffff), 0,
                       none});
      rows.push_back('{mk(fsr_pkg::KIND_VLINE, 7, 120, 0, 200, 0, 0, 0, 32'h7), 0, none});
      rows.push_back('{mk(fsr_pkg::KIND_FILL, 0, 0, 255, 255, 0, 0, 0, 32'hffff_ffff), 0,
                       none});
      rows.push_back('{mk(fsr_pkg::KIND_FILL, 4, 4, 0, 9, 0, 0, 0, 32'h3), 1,
                       '{0, fsr_pkg::STATUS_OK}});
      rows.push_back('{mk(fsr_pkg::KIND_RECT, 5, 5, 6, 4, 0, 0, 0, 32'h1234_0004), 0, none});
      rows.push_back('{mk(fsr_pkg::KIND_RECT, 30, 30, 1, 1, 0, 0, 0, 32'h4), 0, none});
      rows.push_back('{mk(fsr_pkg::KIND_GRID, 1, 1, 8, 8, 0, 3, 0, 32'h5), 1,
                       '{0, fsr_pkg::STATUS_ZERO_DIV}});
      rows.push_back('{mk(fsr_pkg::KIND_GRID, 1, 1, 8, 8, 3, 0, 0, 32'h5), 1,
                       '{0, fsr_pkg::STATUS_ZERO_DIV}});
      rows.push_back('{mk(fsr_pkg::KIND_GRID, 10, 10, 20, 12, 4, 3, 0, 32'h0055_0005), 0,
                       none});
      rows.push_back('{mk(fsr_pkg::KIND_GRID, 10, 10, 0, 0, 3, 3, 0, 32'h5), 1,
                       '{0, fsr_pkg::STATUS_OK}});
      rows.push_back('{mk(fsr_pkg::KIND_RING, 40, 40, 0, 0, 0, 0, 0, 32'h6), 0, none});
      rows.push_back('{mk(fsr_pkg::KIND_RING, 20, 60, 0, 0, 0, 0, 21, 32'h0066_0006), 0,
                       none});
      rows.push_back('{mk(fsr_pkg::KIND_DISC, 0, 0, 0, 0, 0, 0, 1, 32'h7), 0, none});
      rows.push_back('{mk(fsr_pkg::KIND_DISC, 0, 0, 0, 0, 0, 0, 255, 32'h8000_0007), 0,
                       none});
      rows.push_back('{mk(fsr_pkg::KIND_RING, 100, 100, 0, 0, 0, 0, 254, 32'h0077_0000), 0,
                       none});
      rows.push_back('{mk(KIND_SPARE_HI, 1, 1, 1, 1, 1, 1, 1, 32'h9), 1,
                       '{0, fsr_pkg::STATUS_OK}});
      rows.push_back('{mk(KIND_SPARE_LO, 2, 2, 2, 2, 2, 2, 2, 32'h9), 1,
                       '{0, fsr_pkg::STATUS_OK}});
      rows.push_back('{mk(fsr_pkg::KIND_READ, 64, 64, 0, 0, 0, 0, 0, 0), 0, none});
      rows.push_back('{mk(fsr_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 32'h1234_5678), 1,
                       '{0, fsr_pkg::STATUS_OK}});
      rows.push_back('{mk(fsr_pkg::KIND_READ, 127, 127, 0, 0, 0, 0, 0, 0), 1,
                       '{32'h1234_5678, fsr_pkg::STATUS_OK}});
      rows.push_back('{mk(fsr_pkg::KIND_READ, 128, 0, 0, 0, 0, 0, 0, 0), 1,
                       '{0, fsr_pkg::STATUS_CLIP}});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         issue_cmd(rows[i].c, rows[i].typed, rows[i].r);
         if ($urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 50) begin
            start <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         issue_cmd(rand_cmd(), 0, none);
         if ((i < 20 || i > 60) && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      start <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d commands (directed edge cases plus random shapes, reads, clears)",
               n_sent);
      $display("checked %0d results against the frame model, %0d mismatches",
               n_checked, errors);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
